// ===== rtl/vfc_pkg.sv =====
// Shared constants, types and codes of the voxel face culling store.
package vfc_pkg;

	// Grid size in voxels along each axis
	localparam int GRID_WIDTH  = 16;
	localparam int GRID_HEIGHT = 16;
	localparam int GRID_DEPTH  = 16;

	localparam int PLANE      = GRID_WIDTH * GRID_HEIGHT;
	localparam int CELL_COUNT = PLANE * GRID_DEPTH;

	// Coordinate bits actually used once a coordinate is known to be in range
	localparam int XW     = $clog2(GRID_WIDTH);
	localparam int YW     = $clog2(GRID_HEIGHT);
	localparam int ZW     = $clog2(GRID_DEPTH);
	localparam int CELL_W = $clog2(CELL_COUNT);

	localparam logic [1:0] TYPE_GAS   = 2'd0;
	localparam logic [1:0] TYPE_SOLID = 2'd1;

	// Face bit positions in the mask
	localparam int FACE_XN = 0;
	localparam int FACE_XP = 1;
	localparam int FACE_YN = 2;
	localparam int FACE_YP = 3;
	localparam int FACE_ZN = 4;
	localparam int FACE_ZP = 5;

	typedef logic [CELL_W-1:0] cell_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FINISH,
		ST_READ,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Decoded command
	typedef struct packed {
		opcode_t    op;
		logic       oor;
		cell_idx_t  idx;
		logic [5:0] border;
		logic [1:0] block_type;
	} vfc_cmd_t;

endpackage

// ===== rtl/vfc_decode.sv =====
// Command decode: range check, linear cell index and grid border flags.
module vfc_decode (
	input  logic [1:0]         opcode,
	input  logic [7:0]         x_coord,
	input  logic [7:0]         y_coord,
	input  logic [7:0]         z_coord,
	input  logic [1:0]         block_type,
	output vfc_pkg::vfc_cmd_t  cmd
);
	import vfc_pkg::*;

	logic        x_oor;
	logic        y_oor;
	logic        z_oor;
	logic [31:0] idx_full;

	// Range check on the full 8-bit coordinates
	assign x_oor = {1'b0, x_coord} >= 9'(GRID_WIDTH);
	assign y_oor = {1'b0, y_coord} >= 9'(GRID_HEIGHT);
	assign z_oor = {1'b0, z_coord} >= 9'(GRID_DEPTH);

	// idx = x + W*(y + H*z), constant multipliers only
	assign idx_full = 32'(z_coord[ZW-1:0]) * 32'(PLANE)
	                + 32'(y_coord[YW-1:0]) * 32'(GRID_WIDTH)
	                + 32'(x_coord[XW-1:0]);

	always_comb begin
		cmd.op         = opcode_t'(opcode);
		cmd.oor        = (opcode_t'(opcode) != OP_NONE) && (x_oor || y_oor || z_oor);
		cmd.idx        = idx_full[CELL_W-1:0];
		cmd.block_type = block_type;
		cmd.border[FACE_XN] = x_coord == 8'd0;
		cmd.border[FACE_XP] = x_coord == 8'(GRID_WIDTH - 1);
		cmd.border[FACE_YN] = y_coord == 8'd0;
		cmd.border[FACE_YP] = y_coord == 8'(GRID_HEIGHT - 1);
		cmd.border[FACE_ZN] = z_coord == 8'd0;
		cmd.border[FACE_ZP] = z_coord == 8'(GRID_DEPTH - 1);
	end

endmodule

// ===== rtl/voxel_face_culling_store.sv =====
// Top level of the voxel face culling store: command FSM, voxel memory, result register.
//
// Holds a GRID_WIDTH x GRID_HEIGHT x GRID_DEPTH grid of 2-bit voxel types in one
// synchronous memory with one write port and two read ports. After reset the block
// runs a clearing pass that writes gas to every entry, one per cycle, and takes no
// beat until it is done. Commands are handled one at a time, and a face query
// reads the voxel and its six neighbors, which the two read ports fetch in four
// passes. A finished result sits in an output register, so the next command is
// taken while it waits.
module voxel_face_culling_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // x_coord[7:0], y_coord[15:8], z_coord[23:16], block_type[25:24]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // read_type[1:0], face_mask[7:2]
	output logic        m_tuser   // out_of_range[0]
);
	import vfc_pkg::*;

	state_t     state_q, state_d;
	vfc_cmd_t   cmd_in, cmd_q;
	cell_idx_t  clr_q;
	logic [1:0] step_q;

	// Voxel memory
	logic [1:0] mem [CELL_COUNT];
	logic       mem_we;
	cell_idx_t  mem_waddr;
	logic [1:0] mem_wdata;
	cell_idx_t  rd_addr_a, rd_addr_b;
	logic [1:0] rd_a_s1, rd_b_s1;
	logic       rd_vld_s1;
	logic [1:0] rd_step_s1;

	// Gathered read results: bit 6 center solid, bits 5:0 neighbors in face order
	logic [6:0] sol_q;
	logic [1:0] type_q;

	// Output register
	logic       out_vld_q;
	logic [1:0] out_type_q;
	logic [5:0] out_mask_q;
	logic       out_oor_q;
	logic       out_free;
	logic       load_out;
	logic [1:0] res_type;
	logic [5:0] res_mask;
	logic       res_oor;
	logic       last_step;

	vfc_decode u_decode (
		.opcode     (s_tuser),
		.x_coord    (s_tdata[7:0]),
		.y_coord    (s_tdata[15:8]),
		.z_coord    (s_tdata[23:16]),
		.block_type (s_tdata[25:24]),
		.cmd        (cmd_in)
	);

	assign out_free  = !out_vld_q || m_tready;
	assign last_step = (cmd_q.op != OP_QUERY) || (step_q == 2'd3);

	// Next state, memory control and result forming
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cmd_q.idx;
		mem_wdata = cmd_q.block_type;
		rd_addr_a = cmd_q.idx;
		rd_addr_b = cmd_q.idx - CELL_W'(1);
		load_out  = 1'b0;
		res_type  = TYPE_GAS;
		res_mask  = '0;
		res_oor   = cmd_q.oor;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = TYPE_GAS;
				if (clr_q == CELL_W'(CELL_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (!cmd_in.oor && (cmd_in.op == OP_READ || cmd_in.op == OP_QUERY)) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					mem_we   = (cmd_q.op == OP_WRITE) && !cmd_q.oor;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				// Two reads per pass: center and six neighbors over four passes
				unique case (step_q)
					2'd0: begin
						rd_addr_a = cmd_q.idx;
						rd_addr_b = cmd_q.idx - CELL_W'(1);
					end
					2'd1: begin
						rd_addr_a = cmd_q.idx + CELL_W'(1);
						rd_addr_b = cmd_q.idx - CELL_W'(GRID_WIDTH);
					end
					2'd2: begin
						rd_addr_a = cmd_q.idx + CELL_W'(GRID_WIDTH);
						rd_addr_b = cmd_q.idx - CELL_W'(PLANE);
					end
					default: begin
						rd_addr_a = cmd_q.idx + CELL_W'(PLANE);
						rd_addr_b = cmd_q.idx;
					end
				endcase
				if (last_step) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (cmd_q.op == OP_READ) begin
					res_type = type_q;
				end else if (sol_q[6]) begin
					res_mask = cmd_q.border | ~sol_q[5:0];
				end
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			step_q     <= '0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= state_q == ST_READ;
			out_vld_q <= load_out || (out_vld_q && !m_tready);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CELL_W'(1);
			end
			if (state_q == ST_READ) begin
				step_q <= step_q + 2'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Command register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd_in;
		end
	end

	// Voxel memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a_s1    <= mem[rd_addr_a];
		rd_b_s1    <= mem[rd_addr_b];
		rd_step_s1 <= step_q;
	end

	// Collect read data
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			unique case (rd_step_s1)
				2'd0: begin
					type_q         <= rd_a_s1;
					sol_q[6]       <= rd_a_s1 == TYPE_SOLID;
					sol_q[FACE_XN] <= rd_b_s1 == TYPE_SOLID;
				end
				2'd1: begin
					sol_q[FACE_XP] <= rd_a_s1 == TYPE_SOLID;
					sol_q[FACE_YN] <= rd_b_s1 == TYPE_SOLID;
				end
				2'd2: begin
					sol_q[FACE_YP] <= rd_a_s1 == TYPE_SOLID;
					sol_q[FACE_ZN] <= rd_b_s1 == TYPE_SOLID;
				end
				default: begin
					sol_q[FACE_ZP] <= rd_a_s1 == TYPE_SOLID;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_type_q <= res_type;
			out_mask_q <= res_mask;
			out_oor_q  <= res_oor;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_mask_q, out_type_q};
	assign m_tuser  = out_oor_q;

endmodule

// ===== tb/vfc_result_checker.sv =====
// Scoreboard for the voxel face culling store: predicts every result beat and checks it.
`timescale 1ns / 100ps
module vfc_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // x_coord[7:0], y_coord[15:8], z_coord[23:16], block_type[25:24]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // read_type[1:0], face_mask[7:2]
	input  logic        m_tuser,  // out_of_range[0]
	output int          fail_count,
	output int          outstanding
);
	import vfc_pkg::*;

	typedef struct packed {
		logic [1:0] read_type;
		logic [5:0] face_mask;
		logic       out_of_range;
	} voxel_result_t;

	// Shadow copy of the voxel grid and results still owed by the block
	logic [1:0]    voxel_shadow [CELL_COUNT];
	voxel_result_t expected_results [$];

	function automatic int cell_of(int x, int y, int z);
		return x + GRID_WIDTH * (y + GRID_HEIGHT * z);
	endfunction

	function automatic logic solid_at(int x, int y, int z);
		return voxel_shadow[cell_of(x, y, z)] == TYPE_SOLID;
	endfunction

	// A solid voxel's face shows on the grid border or next to anything that is not solid
	function automatic logic [5:0] visible_faces(int x, int y, int z);
		logic [5:0] faces;
		faces = '0;
		if (!solid_at(x, y, z))
			return faces;
		faces[FACE_XN] = (x == 0) ? 1'b1 : !solid_at(x - 1, y, z);
		faces[FACE_XP] = (x == GRID_WIDTH - 1) ? 1'b1 : !solid_at(x + 1, y, z);
		faces[FACE_YN] = (y == 0) ? 1'b1 : !solid_at(x, y - 1, z);
		faces[FACE_YP] = (y == GRID_HEIGHT - 1) ? 1'b1 : !solid_at(x, y + 1, z);
		faces[FACE_ZN] = (z == 0) ? 1'b1 : !solid_at(x, y, z - 1);
		faces[FACE_ZP] = (z == GRID_DEPTH - 1) ? 1'b1 : !solid_at(x, y, z + 1);
		return faces;
	endfunction

	// Runs one command against the shadow grid and returns the result it owes
	function automatic voxel_result_t apply_command(opcode_t op, logic [7:0] x, logic [7:0] y,
			logic [7:0] z, logic [1:0] kind);
		voxel_result_t res;
		int            idx;
		res = '0;
		if (op == OP_NONE)
			return res;
		res.out_of_range = (x >= GRID_WIDTH) || (y >= GRID_HEIGHT) || (z >= GRID_DEPTH);
		if (res.out_of_range)
			return res;
		idx = cell_of(x, y, z);
		case (op)
			OP_WRITE: voxel_shadow[idx] = kind;
			OP_READ:  res.read_type = voxel_shadow[idx];
			OP_QUERY: res.face_mask = visible_faces(x, y, z);
			default: ;
		endcase
		return res;
	endfunction

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Result beats are matched first, then the accepted command is predicted
	always @(posedge clk) begin
		voxel_result_t want, got;
		if (!arst_n) begin
			foreach (voxel_shadow[i])
				voxel_shadow[i] = TYPE_GAS;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{read_type: m_tdata[1:0], face_mask: m_tdata[7:2], out_of_range: m_tuser};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected beat, expected none actual tdata %h tuser %b",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_type", want.read_type, got.read_type);
					check_field("face_mask", want.face_mask, got.face_mask);
					check_field("out_of_range", want.out_of_range, got.out_of_range);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_command(opcode_t'(s_tuser), s_tdata[7:0],
					s_tdata[15:8], s_tdata[23:16], s_tdata[25:24]));
		end
		outstanding = expected_results.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the voxel face culling store testbench: clock, reset, commands and verdict.
`timescale 1ns / 100ps
module testbench;
	import vfc_pkg::*;

	localparam int ITEM_COUNT   = 1700;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;

	// Non-solid kinds besides gas
	localparam logic [1:0] TYPE_FLUID   = 2'd2;
	localparam logic [1:0] TYPE_FOLIAGE = 2'd3;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	int fail_count;
	int outstanding;
	int tx_idle_pct = 14;
	int rx_idle_pct = 51;
	bit hold_armed  = 1'b0;
	bit held_off    = 1'b0;

	always #5 clk = ~clk;

	voxel_face_culling_store i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	vfc_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Offer one command beat, with random idle cycles ahead of it
	task automatic issue_command(opcode_t op, logic [7:0] x, logic [7:0] y, logic [7:0] z,
			logic [1:0] kind);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, kind, z, y, x};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	// Mostly a dense cluster so neighbors are often solid, plus borders and spread
	function automatic logic [7:0] pick_axis(int span);
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 8'($urandom_range(span / 4 + 3, span / 4));
		if (r < 75)
			return ($urandom_range(1) != 0) ? 8'(span - 1) : 8'd0;
		return 8'($urandom_range(span - 1));
	endfunction

	task automatic issue_random_command();
		opcode_t    op;
		logic [7:0] x, y, z;
		logic [1:0] kind;
		int         r;
		r    = $urandom_range(99);
		op   = (r < 40) ? OP_WRITE : (r < 60) ? OP_READ : (r < 95) ? OP_QUERY : OP_NONE;
		x    = pick_axis(GRID_WIDTH);
		y    = pick_axis(GRID_HEIGHT);
		z    = pick_axis(GRID_DEPTH);
		kind = ($urandom_range(99) < 55) ? TYPE_SOLID : 2'($urandom_range(3));
		// out-of-range noise, with the high coordinate bits exercised
		if ($urandom_range(99) < 10) begin
			x = 8'($urandom_range(255));
			y = 8'($urandom_range(255));
			z = 8'($urandom_range(255));
			case ($urandom_range(2))
				0: x = 8'($urandom_range(255, GRID_WIDTH));
				1: y = 8'($urandom_range(255, GRID_HEIGHT));
				default: z = 8'($urandom_range(255, GRID_DEPTH));
			endcase
		end
		issue_command(op, x, y, z, kind);
	endtask

	// Receiver: random back-pressure, and one long hold-off once armed
	initial begin
		forever begin
			@(posedge clk);
			if (hold_armed && !held_off) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Commands and verdict
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// lone voxel at the origin corner, then a neighbor hiding one face
		issue_command(OP_QUERY, 8'd0, 8'd0, 8'd0, TYPE_GAS);
		issue_command(OP_WRITE, 8'd0, 8'd0, 8'd0, TYPE_SOLID);
		issue_command(OP_QUERY, 8'd0, 8'd0, 8'd0, TYPE_GAS);
		issue_command(OP_WRITE, 8'd1, 8'd0, 8'd0, TYPE_SOLID);
		issue_command(OP_QUERY, 8'd0, 8'd0, 8'd0, TYPE_GAS);
		issue_command(OP_QUERY, 8'd1, 8'd0, 8'd0, TYPE_GAS);
		// non-solid voxel: readable, but no faces
		issue_command(OP_WRITE, 8'd0, 8'd1, 8'd0, TYPE_FLUID);
		issue_command(OP_QUERY, 8'd0, 8'd1, 8'd0, TYPE_GAS);
		issue_command(OP_READ, 8'd0, 8'd1, 8'd0, TYPE_GAS);
		issue_command(OP_QUERY, 8'd0, 8'd0, 8'd0, TYPE_GAS);
		// far corner
		issue_command(OP_WRITE, 8'(GRID_WIDTH - 1), 8'(GRID_HEIGHT - 1), 8'(GRID_DEPTH - 1),
			TYPE_FOLIAGE);
		issue_command(OP_READ, 8'(GRID_WIDTH - 1), 8'(GRID_HEIGHT - 1), 8'(GRID_DEPTH - 1),
			TYPE_GAS);
		issue_command(OP_WRITE, 8'(GRID_WIDTH - 1), 8'(GRID_HEIGHT - 1), 8'(GRID_DEPTH - 1),
			TYPE_SOLID);
		issue_command(OP_QUERY, 8'(GRID_WIDTH - 1), 8'(GRID_HEIGHT - 1), 8'(GRID_DEPTH - 1),
			TYPE_GAS);
		// coordinates outside the grid: writes dropped, type and mask zero, out_of_range set
		issue_command(OP_WRITE, 8'(GRID_WIDTH), 8'(GRID_HEIGHT - 1), 8'(GRID_DEPTH - 1),
			TYPE_GAS);
		issue_command(OP_READ, 8'(GRID_WIDTH - 1), 8'd255, 8'(GRID_DEPTH - 1), TYPE_GAS);
		issue_command(OP_QUERY, 8'(GRID_WIDTH - 1), 8'(GRID_HEIGHT - 1), 8'd128, TYPE_GAS);
		issue_command(OP_WRITE, 8'd255, 8'd255, 8'd255, TYPE_FOLIAGE);
		issue_command(OP_READ, 8'(GRID_WIDTH - 1), 8'(GRID_HEIGHT - 1), 8'(GRID_DEPTH - 1),
			TYPE_GAS);
		// unused opcode, both out of and inside the grid
		issue_command(OP_NONE, 8'd255, 8'd255, 8'd255, TYPE_FOLIAGE);
		issue_command(OP_NONE, 8'd0, 8'd0, 8'd0, TYPE_FOLIAGE);
		// clearing a neighbor exposes the face again; untouched cell reads gas
		issue_command(OP_WRITE, 8'd1, 8'd0, 8'd0, TYPE_GAS);
		issue_command(OP_QUERY, 8'd0, 8'd0, 8'd0, TYPE_GAS);
		issue_command(OP_READ, 8'd8, 8'd8, 8'd8, TYPE_GAS);

		// random traffic in three idling phases
		for (int i = 0; i < ITEM_COUNT; i++) begin
			if (i == ITEM_COUNT / 3) begin
				tx_idle_pct = 51;
				rx_idle_pct = 14;
			end
			if (i == 2 * ITEM_COUNT / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_armed  = 1'b1;
			end
			issue_random_command();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/vfc_pkg.sv
rtl/vfc_decode.sv
rtl/voxel_face_culling_store.sv
tb/vfc_result_checker.sv
tb/testbench.sv
